### rtl/mbt_pkg.sv
`timescale 1ns / 1ps
// Package for the multiset bag table: operation codes used by the top level.
// No dependencies.
package mbt_pkg;

    localparam int FUNC_W = 2;

    typedef logic [FUNC_W-1:0] func_t;

    localparam func_t FUNC_ADD      = 2'd0;
    localparam func_t FUNC_CONTAINS = 2'd1;
    localparam func_t FUNC_REMOVE   = 2'd2;
    localparam func_t FUNC_NONE     = 2'd3;

endpackage

### rtl/mbt_ram.sv
`timescale 1ns / 1ps
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module mbt_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/multiset_bag_table_top.sv
`timescale 1ns / 1ps
// Top level of the multiset bag table: control sequencer, slot memory and result register.
// Depends on mbt_pkg and mbt_ram.

// The bag holds up to CAPACITY signed values in one slot memory, each word a valid bit
// and a value. After reset the block clears the valid bits and holds in_ready low
// meanwhile. Each word gives one result word. An add into a full bag and the unused
// function code skip the scan; every other request scans the slot memory one slot per
// cycle through its single read port and stops at the first free slot (add) or first
// matching slot (contains, remove), or after the last slot when nothing matches. The next
// word is taken while a finished result still waits in the output register.
module multiset_bag_table_top #(
    parameter int CAPACITY   = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  mbt_pkg::func_t                   func,
    input  logic signed [VALUE_BITS-1:0]     value,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             hit,
    output logic                             rejected,
    output logic [$clog2(CAPACITY+1)-1:0]    count,
    output logic                             empty_res
);

    import mbt_pkg::*;

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int WORD_W = VALUE_BITS + 1;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic [1:0]            state_reg, state_next;
    logic [CNT_W-1:0]      scan_idx_reg, scan_idx_next;
    logic                  chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0]      chk_idx_reg, chk_idx_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  out_valid_reg, out_valid_next;

    func_t                 func_reg, func_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;
    logic                  res_hit_reg, res_hit_next;
    logic                  res_rej_reg, res_rej_next;
    logic                  hit_reg, hit_next;
    logic                  rej_reg, rej_next;
    logic [CNT_W-1:0]      out_count_reg, out_count_next;
    logic                  empty_reg, empty_next;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [WORD_W-1:0]     ram_wdata;
    logic                  ram_re;
    logic [IDX_W-1:0]      ram_raddr;
    logic [WORD_W-1:0]     ram_rdata;

    logic                  slot_used;
    logic                  slot_match;
    logic                  found;
    logic                  accept;
    logic                  out_load;

    mbt_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CAPACITY)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    assign slot_used  = ram_rdata[VALUE_BITS];
    assign slot_match = slot_used && (ram_rdata[VALUE_BITS-1:0] == value_reg);
    assign found      = chk_valid_reg &&
                        ((func_reg == FUNC_ADD) ? !slot_used : slot_match);

    always_comb
    begin
        state_next     = state_reg;
        scan_idx_next  = scan_idx_reg;
        chk_valid_next = chk_valid_reg;
        chk_idx_next   = chk_idx_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        func_next      = func_reg;
        value_next     = value_reg;
        res_hit_next   = res_hit_reg;
        res_rej_next   = res_rej_reg;
        hit_next       = hit_reg;
        rej_next       = rej_reg;
        out_count_next = out_count_reg;
        empty_next     = empty_reg;

        ram_we    = 1'b0;
        ram_waddr = chk_idx_reg;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = scan_idx_reg[IDX_W-1:0];

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = scan_idx_reg[IDX_W-1:0];
                ram_wdata = '0;
                if (scan_idx_reg == CAP_CNT - CNT_W'(1))
                begin
                    state_next = ST_IDLE;
                end
                scan_idx_next = scan_idx_reg + CNT_W'(1);
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    func_next      = func;
                    value_next     = value;
                    res_hit_next   = 1'b0;
                    res_rej_next   = 1'b0;
                    scan_idx_next  = '0;
                    chk_valid_next = 1'b0;
                    if (func == FUNC_NONE)
                    begin
                        state_next = ST_DONE;
                    end
                    else if ((func == FUNC_ADD) && (count_reg == CAP_CNT))
                    begin
                        res_rej_next = 1'b1;
                        state_next   = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // Reads are issued one slot ahead of the compare on the returned word.
                if (found)
                begin
                    state_next = ST_DONE;
                    case (func_reg)
                        FUNC_ADD:
                        begin
                            ram_we     = 1'b1;
                            ram_wdata  = {1'b1, value_reg};
                            count_next = count_reg + CNT_W'(1);
                        end
                        FUNC_REMOVE:
                        begin
                            ram_we       = 1'b1;
                            ram_wdata    = '0;
                            count_next   = count_reg - CNT_W'(1);
                            res_hit_next = 1'b1;
                        end
                        default:
                        begin
                            res_hit_next = 1'b1;
                        end
                    endcase
                end
                else if (scan_idx_reg == CAP_CNT)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    ram_re         = 1'b1;
                    chk_valid_next = 1'b1;
                    chk_idx_next   = scan_idx_reg[IDX_W-1:0];
                    scan_idx_next  = scan_idx_reg + CNT_W'(1);
                end
            end

            ST_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    hit_next       = res_hit_reg;
                    rej_next       = res_rej_reg;
                    out_count_next = count_reg;
                    empty_next     = (count_reg == '0);
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            scan_idx_reg  <= '0;
            chk_valid_reg <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_idx_reg  <= scan_idx_next;
            chk_valid_reg <= chk_valid_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg   <= chk_idx_next;
        func_reg      <= func_next;
        value_reg     <= value_next;
        res_hit_reg   <= res_hit_next;
        res_rej_reg   <= res_rej_next;
        hit_reg       <= hit_next;
        rej_reg       <= rej_next;
        out_count_reg <= out_count_next;
        empty_reg     <= empty_next;
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign rejected  = rej_reg;
    assign count     = out_count_reg;
    assign empty_res = empty_reg;

endmodule

### rtl/mbt_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the multiset bag table, bound to the top level below.
// Depends on multiset_bag_table_top for the bind target.
module mbt_checker #(
    parameter int CAPACITY   = 16
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic                          hit,
    input logic                          rejected,
    input logic [$clog2(CAPACITY+1)-1:0] count,
    input logic                          empty_res
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // A stalled result word keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(rejected)
            && $stable(count) && $stable(empty_res))
        else $error("result word changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (empty_res == (count == '0)))
        else $error("empty flag disagrees with count");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(hit && rejected))
        else $error("hit and rejected both set");

    // A refused add only happens on a full bag, which it leaves full.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rejected |-> count == CNT_W'(CAPACITY))
        else $error("add rejected while bag not full");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> count <= CNT_W'(CAPACITY))
        else $error("count beyond capacity");

endmodule

bind multiset_bag_table_top mbt_checker #(
    .CAPACITY   (CAPACITY)
) u_mbt_checker (.*);
